// ===== rtl/core/vdpcr_pkg.sv =====
// Shared types, mode codes and pixel helpers for the character-mode cell renderer.
`default_nettype none

package vdpcr_pkg;

  localparam int unsigned AddrW = 17;

  // Mode slots as seen in the display_mode register
  localparam logic [3:0] MODE_GRAPHIC1 = 4'd0;
  localparam logic [3:0] MODE_TEXT1    = 4'd1;
  localparam logic [3:0] MODE_MULTI    = 4'd2;
  localparam logic [3:0] MODE_GRAPHIC2 = 4'd4;
  localparam logic [3:0] MODE_TEXT1Q   = 4'd5;
  localparam logic [3:0] MODE_MULTIQ   = 4'd6;
  localparam logic [3:0] MODE_GRAPHIC3 = 4'd8;
  localparam logic [3:0] MODE_TEXT2    = 4'd9;

  // Configuration register indexes
  localparam logic [2:0] REG_DISPLAY_MODE  = 3'd0;
  localparam logic [2:0] REG_NAME_MASK     = 3'd1;
  localparam logic [2:0] REG_PATTERN_MASK  = 3'd2;
  localparam logic [2:0] REG_COLOUR_MASK   = 3'd3;
  localparam logic [2:0] REG_TEXT_FG       = 3'd4;
  localparam logic [2:0] REG_TEXT_BG       = 3'd5;
  localparam logic [2:0] REG_BLINK_FG      = 3'd6;
  localparam logic [2:0] REG_BLINK_BG      = 3'd7;

  // Command opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  localparam logic [3:0] CNT_FULL = 4'd8;
  localparam logic [3:0] CNT_TEXT = 4'd6;

  // Last inner column of a bogus-mode line
  localparam logic [6:0] BOGUS_LAST_COL = 7'd40;

  typedef enum logic [2:0] {
    RULE_G1,
    RULE_G2,
    RULE_T1,
    RULE_T1Q,
    RULE_T2,
    RULE_MC,
    RULE_MCQ,
    RULE_BOGUS
  } rule_e;

  typedef struct packed {
    logic        opcode;
    logic [16:0] mem_address;
    logic [7:0]  mem_data;
    logic [7:0]  scan_line;
    logic [6:0]  cell_column;
    logic        blink_phase;
  } cmd_t;

  typedef struct packed {
    logic [31:0] pixel_colours;
    logic [3:0]  pixel_count;
    logic        doubled;
  } result_t;

  function automatic rule_e decode_rule(logic [3:0] mode);
    rule_e r;
    case (mode)
      MODE_GRAPHIC1: r = RULE_G1;
      MODE_GRAPHIC2: r = RULE_G2;
      MODE_GRAPHIC3: r = RULE_G2;
      MODE_TEXT1:    r = RULE_T1;
      MODE_TEXT1Q:   r = RULE_T1Q;
      MODE_TEXT2:    r = RULE_T2;
      MODE_MULTI:    r = RULE_MC;
      MODE_MULTIQ:   r = RULE_MCQ;
      default:       r = RULE_BOGUS;
    endcase
    return r;
  endfunction

  // Spread a pattern byte MSB first into 4-bit indices; six-pixel cells leave the last two at 0.
  function automatic logic [31:0] expand(logic [7:0] pat, logic [3:0] fg, logic [3:0] bg,
                                         logic six);
    logic [31:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      if (!(six && i >= 6)) begin
        w[31 - 4 * i -: 4] = pat[7 - i] ? fg : bg;
      end
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vdpcr_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module vdpcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 131072
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/vdp_character_mode_cell_renderer.sv =====
// Character-mode cell renderer: video memory, mode address former and read sequencer.
//
// Commands enter on cmd_i and transfer at a rising edge with start high and busy low.
// A write command stores mem_data at mem_address in the same edge; busy stays low, so
// another command may follow in the very next cycle, and it gives no result.
// A render command steps the sequencer through RD1, RD2 and FIN with busy high: the
// video memory has one port with a registered read, and the name, pattern and colour
// bytes are fetched one after another through it (the first read is issued in the
// transfer cycle). The result appears on result_o with done_o high for exactly one
// cycle, the cycle after the sequencer finishes, which is also the first cycle in
// which busy is low again.
// The receiver cannot stall: sample result_o whenever done_o is high.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i by the user only while
// no render is in flight, not enforced by the block; a write takes effect at that edge.
// Reset puts the sequencer in idle, drops done_o and loads the register defaults; the
// video memory keeps no reset value, so bytes must be written before a render reads them.
`default_nettype none

module vdp_character_mode_cell_renderer #(
  parameter int unsigned MEM_ADDR_BITS = 17
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire vdpcr_pkg::cmd_t            cmd_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [2:0]                 cfg_idx_i,
  input  wire logic [16:0]                cfg_wdata_i,
  output logic                            done_o,
  output vdpcr_pkg::result_t              result_o
);

  localparam int unsigned MemDepth = 1 << MEM_ADDR_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD1  = 2'd1;
  localparam logic [1:0] ST_RD2  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [3:0]  mode_q;
  logic [16:0] nmask_q, pmask_q, cmask_q;
  logic [3:0]  tfg_q, tbg_q, bfg_q, bbg_q;

  logic [7:0]  line_q;
  logic [6:0]  col_q;
  logic        blink_q;
  logic [11:0] name_q;
  logic [7:0]  b0_q, b1_q;
  logic        done_q;
  vdpcr_pkg::result_t res_q, res_d;

  vdpcr_pkg::rule_e rule;
  logic        accept;
  logic        ram_we;
  logic [16:0] addr_full;
  logic [7:0]  rdata;
  logic [4:0]  in_row;
  logic [11:0] in_name;
  logic [4:0]  row;
  logic [2:0]  fine;
  logic [2:0]  mfine;
  logic [9:0]  pnr;
  logic [9:0]  cnr;
  logic        blink_hit;
  logic [3:0]  t2_fg, t2_bg;

  assign rule   = vdpcr_pkg::decode_rule(mode_q);
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign ram_we = accept && (cmd_i.opcode == vdpcr_pkg::OP_WRITE);

  assign row   = line_q[7:3];
  assign fine  = line_q[2:0];
  assign mfine = line_q[4:2];

  // Name index from the incoming command: row * stride + column
  assign in_row = cmd_i.scan_line[7:3];
  always_comb begin
    case (rule)
      vdpcr_pkg::RULE_T1, vdpcr_pkg::RULE_T1Q:
        in_name = {4'b0, in_row, 3'b0} + {2'b0, in_row, 5'b0} + {5'b0, cmd_i.cell_column};
      vdpcr_pkg::RULE_T2:
        in_name = {3'b0, in_row, 4'b0} + {1'b0, in_row, 6'b0} + {5'b0, cmd_i.cell_column};
      default:
        in_name = {2'b0, in_row, 5'b0} + {5'b0, cmd_i.cell_column};
    endcase
  end

  // Pattern and colour numbers with the screen-third quarter folded in
  assign pnr = {row[4] & pmask_q[12], row[3] & pmask_q[11], rdata};
  assign cnr = {row[4:3], b0_q} & cmask_q[12:3];

  // Address former shared by every fetch step
  always_comb begin
    addr_full = '0;
    case (state_q)
      ST_IDLE: begin
        if (ram_we) begin
          addr_full = cmd_i.mem_address;
        end else if (rule == vdpcr_pkg::RULE_T2) begin
          addr_full = cmask_q & {8'hFF, in_name[11:3]};
        end else begin
          addr_full = {nmask_q[16:10], 10'b0} | {5'b0, in_name};
        end
      end
      ST_RD1: begin
        case (rule)
          vdpcr_pkg::RULE_T2:
            addr_full = nmask_q & {5'h1F, name_q};
          vdpcr_pkg::RULE_G1, vdpcr_pkg::RULE_T1:
            addr_full = ({6'h3F, 8'h00, fine} & pmask_q) | {6'b0, rdata, 3'b0};
          vdpcr_pkg::RULE_MC:
            addr_full = ({6'h3F, 8'h00, mfine} & pmask_q) | {6'b0, rdata, 3'b0};
          vdpcr_pkg::RULE_G2, vdpcr_pkg::RULE_T1Q:
            addr_full = ({4'hF, 10'h000, fine} & pmask_q) | {4'b0, pnr, 3'b0};
          vdpcr_pkg::RULE_MCQ:
            addr_full = ({4'hF, 10'h000, mfine} & pmask_q) | {4'b0, pnr, 3'b0};
          default:
            addr_full = '0;
        endcase
      end
      ST_RD2: begin
        case (rule)
          vdpcr_pkg::RULE_T2:
            addr_full = ({6'h3F, 8'h00, fine} & pmask_q) | {6'b0, rdata, 3'b0};
          vdpcr_pkg::RULE_G1:
            addr_full = {cmask_q[16:6], 6'b0} | {12'b0, b0_q[7:3]};
          vdpcr_pkg::RULE_G2:
            addr_full = ({4'hF, 10'h000, fine} & cmask_q) | {4'b0, cnr, 3'b0};
          default:
            addr_full = '0;
        endcase
      end
      default: addr_full = '0;
    endcase
  end

  vdpcr_ram #(
    .WIDTH(8),
    .DEPTH(MemDepth)
  ) u_vram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (addr_full[MEM_ADDR_BITS-1:0]),
    .wdata_i(cmd_i.mem_data),
    .rdata_o(rdata)
  );

  // Text2 blink attribute bit for this cell
  assign blink_hit = b0_q[3'd7 - name_q[2:0]] && blink_q;
  assign t2_fg     = !blink_hit ? tfg_q : ((bfg_q != 4'd0) ? bfg_q : bbg_q);
  assign t2_bg     = blink_hit ? bbg_q : tbg_q;

  always_comb begin
    res_d.pixel_count = vdpcr_pkg::CNT_FULL;
    res_d.doubled     = 1'b1;
    case (rule)
      vdpcr_pkg::RULE_G1, vdpcr_pkg::RULE_G2: begin
        res_d.pixel_colours = vdpcr_pkg::expand(b1_q, rdata[7:4], rdata[3:0], 1'b0);
      end
      vdpcr_pkg::RULE_T1, vdpcr_pkg::RULE_T1Q: begin
        res_d.pixel_colours = vdpcr_pkg::expand(b1_q, tfg_q, tbg_q, 1'b1);
        res_d.pixel_count   = vdpcr_pkg::CNT_TEXT;
      end
      vdpcr_pkg::RULE_T2: begin
        res_d.pixel_colours = vdpcr_pkg::expand(rdata, t2_fg, t2_bg, 1'b1);
        res_d.pixel_count   = vdpcr_pkg::CNT_TEXT;
        res_d.doubled       = 1'b0;
      end
      vdpcr_pkg::RULE_MC, vdpcr_pkg::RULE_MCQ: begin
        res_d.pixel_colours = vdpcr_pkg::expand(8'hF0, b1_q[7:4], b1_q[3:0], 1'b0);
      end
      default: begin
        // Border columns are plain background, inner columns a fixed four-on two-off cell
        if (col_q == 7'd0 || col_q > vdpcr_pkg::BOGUS_LAST_COL) begin
          res_d.pixel_colours = vdpcr_pkg::expand(8'h00, tfg_q, tbg_q, 1'b0);
        end else begin
          res_d.pixel_colours = vdpcr_pkg::expand(8'hF0, tfg_q, tbg_q, 1'b1);
          res_d.pixel_count   = vdpcr_pkg::CNT_TEXT;
        end
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i.opcode == vdpcr_pkg::OP_RENDER) begin
          state_d = ST_RD1;
        end
      end
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_FIN;
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      mode_q  <= 4'd0;
      nmask_q <= 17'h1FFFF;
      pmask_q <= 17'h1FFFF;
      cmask_q <= 17'h1FFFF;
      tfg_q   <= 4'd15;
      tbg_q   <= 4'd0;
      bfg_q   <= 4'd0;
      bbg_q   <= 4'd0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_FIN);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          vdpcr_pkg::REG_DISPLAY_MODE: mode_q  <= cfg_wdata_i[3:0];
          vdpcr_pkg::REG_NAME_MASK:    nmask_q <= cfg_wdata_i;
          vdpcr_pkg::REG_PATTERN_MASK: pmask_q <= cfg_wdata_i;
          vdpcr_pkg::REG_COLOUR_MASK:  cmask_q <= cfg_wdata_i;
          vdpcr_pkg::REG_TEXT_FG:      tfg_q   <= cfg_wdata_i[3:0];
          vdpcr_pkg::REG_TEXT_BG:      tbg_q   <= cfg_wdata_i[3:0];
          vdpcr_pkg::REG_BLINK_FG:     bfg_q   <= cfg_wdata_i[3:0];
          vdpcr_pkg::REG_BLINK_BG:     bbg_q   <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end
    end
  end

  // Hold the cell coordinates and the fetched bytes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_q  <= cmd_i.scan_line;
      col_q   <= cmd_i.cell_column;
      blink_q <= cmd_i.blink_phase;
      name_q  <= in_name;
    end
    if (state_q == ST_RD1) begin
      b0_q <= rdata;
    end
    if (state_q == ST_RD2) begin
      b1_q <= rdata;
    end
    if (state_q == ST_FIN) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == ST_FIN)
    else $error("done_o without a finished render");

  a_render_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.opcode == vdpcr_pkg::OP_RENDER) |=> busy)
    else $error("render transfer did not start the sequencer");

  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.opcode == vdpcr_pkg::OP_WRITE) |=> !busy && !done_o)
    else $error("memory write disturbed the sequencer");

  a_fin_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |=> !busy && done_o)
    else $error("sequencer did not release after a result");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the character-mode cell renderer: directed table, then random phases.
module tb_top;
  import vdpcr_pkg::*;

  localparam int unsigned MemDepth = 1 << AddrW;
  localparam int unsigned RunLimit = 8000000;
  localparam int unsigned PhaseCount = 16;
  localparam int unsigned PhaseItems = 50;

  // Mode slots without a package name
  localparam logic [3:0] MODE_BOGUS = 4'd3;
  localparam logic [3:0] MODE_SPARE = 4'd15;

  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  idx;
    logic [16:0] val;
    cmd_t        c;
    logic        has_exp;
    result_t     exp;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  cmd_t        cmd_i;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [16:0] cfg_wdata_i;
  logic        done_o;
  result_t     result_o;

  // Shadow of the block: video memory, which bytes hold data, and the registers
  logic [7:0]       vram     [0:MemDepth-1];
  bit               vram_set [0:MemDepth-1];
  logic [3:0]       sh_mode, sh_tfg, sh_tbg, sh_bfg, sh_bbg;
  logic [16:0]      sh_nmask, sh_pmask, sh_cmask;

  // Addresses touched by the latest cell computation
  logic [AddrW-1:0] fetch_addr [0:3];
  int               fetch_cnt;

  result_t          pending_cells [$];
  plan_row_t        plan [$];
  int               mismatches;
  bit               calm;

  vdp_character_mode_cell_renderer #(.MEM_ADDR_BITS(AddrW)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(RunLimit);
    $display("simulation failed");
    $finish;
  end

  function automatic logic [31:0] spread_pixels(input logic [7:0] pat, input logic [3:0] fg,
                                                input logic [3:0] bg, input int n);
    logic [31:0] w;
    logic [3:0]  px;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      px = (i < n) ? (pat[7 - i] ? fg : bg) : 4'd0;
      w = {w[27:0], px};
    end
    return w;
  endfunction

  function automatic logic [31:0] fetch_byte(input logic [31:0] a);
    fetch_addr[fetch_cnt] = a[AddrW-1:0];
    fetch_cnt++;
    return {24'd0, vram[a[AddrW-1:0]]};
  endfunction

  function automatic result_t render_cell(input cmd_t c);
    logic [31:0] line, col, row, fine, name, code, pat, cb, quarter, nbase, pnr, cnr;
    logic [31:0] nm, pm, cm;
    logic [3:0]  fg, bg;
    result_t     r;
    fetch_cnt = 0;
    nm = {15'd0, sh_nmask};
    pm = {15'd0, sh_pmask};
    cm = {15'd0, sh_cmask};
    line = {24'd0, c.scan_line};
    col = {25'd0, c.cell_column};
    row = line >> 3;
    fine = line & 32'd7;
    nbase = ~32'h3FF & nm;
    fg = sh_tfg;
    bg = sh_tbg;
    r.pixel_colours = '0;
    r.pixel_count = CNT_FULL;
    r.doubled = 1'b1;
    case (sh_mode)
      MODE_GRAPHIC1: begin
        code = fetch_byte(nbase | (row * 32 + col));
        pat = fetch_byte(((~32'h7FF | fine) & pm) | (code << 3));
        cb = fetch_byte((~32'h3F & cm) | (code >> 3));
        r.pixel_colours = spread_pixels(pat[7:0], cb[7:4], cb[3:0], 8);
      end
      MODE_GRAPHIC2, MODE_GRAPHIC3: begin
        quarter = (row * 32) & ~32'hFF;
        code = fetch_byte(nbase | (row * 32 + col));
        pnr = (quarter & (pm >> 3)) | code;
        cnr = (quarter | code) & (32'h3FF & (cm >> 3));
        pat = fetch_byte(((~32'h1FFF | fine) & pm) | (pnr << 3));
        cb = fetch_byte(((~32'h1FFF | fine) & cm) | (cnr << 3));
        r.pixel_colours = spread_pixels(pat[7:0], cb[7:4], cb[3:0], 8);
      end
      MODE_TEXT1: begin
        code = fetch_byte(nbase | (row * 40 + col));
        pat = fetch_byte(((~32'h7FF | fine) & pm) | (code << 3));
        r.pixel_colours = spread_pixels(pat[7:0], fg, bg, 6);
        r.pixel_count = CNT_TEXT;
      end
      MODE_TEXT1Q: begin
        // pattern quarter follows the screen third
        quarter = ((row * 32) & ~32'hFF) & (pm >> 3);
        pnr = fetch_byte(nbase | (row * 40 + col)) | quarter;
        pat = fetch_byte(((~32'h1FFF | fine) & pm) | (pnr << 3));
        r.pixel_colours = spread_pixels(pat[7:0], fg, bg, 6);
        r.pixel_count = CNT_TEXT;
      end
      MODE_TEXT2: begin
        name = row * 80 + col;
        cb = fetch_byte((~32'h1FF | (name >> 3)) & cm);
        if (cb[3'd7 - name[2:0]] && c.blink_phase) begin
          fg = (sh_bfg != 4'd0) ? sh_bfg : sh_bbg;
          bg = sh_bbg;
        end
        code = fetch_byte((~32'hFFF & nm) | (name & 32'hFFF & nm));
        pat = fetch_byte(((~32'h7FF | fine) & pm) | (code << 3));
        r.pixel_colours = spread_pixels(pat[7:0], fg, bg, 6);
        r.pixel_count = CNT_TEXT;
        r.doubled = 1'b0;
      end
      MODE_MULTI: begin
        code = fetch_byte(nbase | (row * 32 + col));
        cb = fetch_byte(((~32'h7FF | ((line >> 2) & 32'd7)) & pm) | (code << 3));
        r.pixel_colours = spread_pixels(8'hF0, cb[7:4], cb[3:0], 8);
      end
      MODE_MULTIQ: begin
        quarter = ((row * 32) & ~32'hFF) & (pm >> 3);
        pnr = quarter | fetch_byte(nbase | (row * 32 + col));
        cb = fetch_byte(((~32'h1FFF | ((line >> 2) & 32'd7)) & pm) | (pnr << 3));
        r.pixel_colours = spread_pixels(8'hF0, cb[7:4], cb[3:0], 8);
      end
      default: begin
        // border cells are plain background, inner cells four fg then two bg
        if (col == 0 || col > {25'd0, BOGUS_LAST_COL}) begin
          r.pixel_colours = spread_pixels(8'h00, fg, bg, 8);
        end else begin
          r.pixel_colours = spread_pixels(8'hF0, fg, bg, 6);
          r.pixel_count = CNT_TEXT;
        end
      end
    endcase
    return r;
  endfunction

  function automatic cmd_t write_cmd(input logic [16:0] addr, input logic [7:0] data);
    cmd_t c;
    c.opcode = OP_WRITE;
    c.mem_address = addr;
    c.mem_data = data;
    c.scan_line = 8'($urandom);
    c.cell_column = 7'($urandom);
    c.blink_phase = 1'($urandom);
    return c;
  endfunction

  function automatic cmd_t render_cmd(input logic [7:0] line, input logic [6:0] col,
                                      input logic blink);
    cmd_t c;
    c.opcode = OP_RENDER;
    c.mem_address = 17'($urandom);
    c.mem_data = 8'($urandom);
    c.scan_line = line;
    c.cell_column = col;
    c.blink_phase = blink;
    return c;
  endfunction

  function automatic plan_row_t cfg_row(input logic [2:0] idx, input logic [16:0] val);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.idx = idx;
    p.val = val;
    return p;
  endfunction

  function automatic plan_row_t cmd_row(input cmd_t c);
    plan_row_t p;
    p = '0;
    p.c = c;
    return p;
  endfunction

  function automatic plan_row_t known_row(input cmd_t c, input logic [31:0] pix,
                                          input logic [3:0] cnt, input logic dbl);
    plan_row_t p;
    p = '0;
    p.c = c;
    p.has_exp = 1'b1;
    p.exp.pixel_colours = pix;
    p.exp.pixel_count = cnt;
    p.exp.doubled = dbl;
    return p;
  endfunction

  function automatic logic [16:0] pick_mask();
    case ($urandom_range(0, 3))
      0: return 17'h1FFFF;
      1: return 17'h00000;
      default: return 17'($urandom);
    endcase
  endfunction

  // Random upper bits check that 4-bit registers drop them
  function automatic logic [16:0] pick_colour();
    logic [16:0] v;
    v = 17'($urandom);
    case ($urandom_range(0, 3))
      0: v[3:0] = 4'd0;
      1: v[3:0] = 4'd15;
      default: v[3:0] = 4'($urandom);
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_DISPLAY_MODE: sh_mode = val[3:0];
      REG_NAME_MASK:    sh_nmask = val;
      REG_PATTERN_MASK: sh_pmask = val;
      REG_COLOUR_MASK:  sh_cmask = val;
      REG_TEXT_FG:      sh_tfg = val[3:0];
      REG_TEXT_BG:      sh_tbg = val[3:0];
      REG_BLINK_FG:     sh_bfg = val[3:0];
      default:          sh_bbg = val[3:0];
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold off until every cell is back and the sequencer has settled
  task automatic drain();
    start <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Offer the command, idling start at random cycles, until it transfers
  task automatic send(input cmd_t c, input logic typed, input result_t known);
    bit offered;
    bit taken;
    cmd_i <= c;
    taken = 1'b0;
    while (!taken) begin
      offered = calm || ($urandom_range(0, 99) >= 32);
      start <= offered;
      @(posedge clk_i);
      taken = offered && !busy;
    end
    if (c.opcode == OP_WRITE) begin
      vram[c.mem_address] = c.mem_data;
      vram_set[c.mem_address] = 1'b1;
    end else begin
      pending_cells.push_back(typed ? known : render_cell(c));
    end
  endtask

  // Write every byte the cell will read that holds no data yet, then render it
  task automatic render(input cmd_t c, input logic typed, input result_t known);
    int k;
    forever begin
      void'(render_cell(c));
      k = -1;
      for (int j = fetch_cnt - 1; j >= 0; j--) begin
        if (!vram_set[fetch_addr[j]]) k = j;
      end
      if (k < 0) break;
      send(write_cmd(fetch_addr[k], 8'($urandom_range(0, 255))), 1'b0, '0);
    end
    send(c, typed, known);
  endtask

  always @(posedge clk_i) begin : check_cells
    result_t want;
    if (rst_ni && done_o) begin
      if (pending_cells.size() == 0) begin
        $display("%0t: cell with none pending: expected none, actual %h", $time, result_o);
        mismatches++;
      end else begin
        want = pending_cells.pop_front();
        if (want.pixel_colours !== result_o.pixel_colours) begin
          $display("%0t: pixel_colours expected %h actual %h", $time,
                   want.pixel_colours, result_o.pixel_colours);
          mismatches++;
        end
        if (want.pixel_count !== result_o.pixel_count) begin
          $display("%0t: pixel_count expected %0d actual %0d", $time,
                   want.pixel_count, result_o.pixel_count);
          mismatches++;
        end
        if (want.doubled !== result_o.doubled) begin
          $display("%0t: doubled expected %0b actual %0b", $time,
                   want.doubled, result_o.doubled);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cmd_t      c;
    plan_row_t pr;
    int        mode_w;
    int        item_no;
    start = 1'b0;
    cmd_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    calm = 1'b0;
    mismatches = 0;
    item_no = 0;
    sh_mode = MODE_GRAPHIC1;
    sh_nmask = 17'h1FFFF;
    sh_pmask = 17'h1FFFF;
    sh_cmask = 17'h1FFFF;
    sh_tfg = 4'd15;
    sh_tbg = 4'd0;
    sh_bfg = 4'd0;
    sh_bbg = 4'd0;

    // Bogus cells under reset colours, then with new text colours
    plan.push_back(cfg_row(REG_DISPLAY_MODE, {13'd0, MODE_BOGUS}));
    plan.push_back(known_row(render_cmd(8'd0, 7'd0, 1'b0), 32'h0000_0000, CNT_FULL, 1'b1));
    plan.push_back(known_row(render_cmd(8'd255, 7'd1, 1'b0), 32'hFFFF_0000, CNT_TEXT, 1'b1));
    plan.push_back(known_row(render_cmd(8'd8, 7'd40, 1'b1), 32'hFFFF_0000, CNT_TEXT, 1'b1));
    plan.push_back(known_row(render_cmd(8'd0, 7'd41, 1'b0), 32'h0000_0000, CNT_FULL, 1'b1));
    plan.push_back(known_row(render_cmd(8'd255, 7'd127, 1'b1), 32'h0000_0000, CNT_FULL, 1'b1));
    plan.push_back(cfg_row(REG_TEXT_FG, 17'h1FFFA));
    plan.push_back(cfg_row(REG_TEXT_BG, 17'h00005));
    plan.push_back(known_row(render_cmd(8'd0, 7'd0, 1'b0), 32'h5555_5555, CNT_FULL, 1'b1));
    plan.push_back(known_row(render_cmd(8'd100, 7'd20, 1'b0), 32'hAAAA_5500, CNT_TEXT, 1'b1));
    plan.push_back(cfg_row(REG_DISPLAY_MODE, {13'd0, MODE_SPARE}));
    plan.push_back(known_row(render_cmd(8'd255, 7'd127, 1'b0), 32'h5555_5555, CNT_FULL, 1'b1));
    plan.push_back(known_row(render_cmd(8'd255, 7'd1, 1'b1), 32'hAAAA_5500, CNT_TEXT, 1'b1));
    // Memory extremes and the real modes
    plan.push_back(cfg_row(REG_DISPLAY_MODE, {13'd0, MODE_GRAPHIC1}));
    plan.push_back(cmd_row(write_cmd(17'h1FFFF, 8'hFF)));
    plan.push_back(cmd_row(write_cmd(17'h00000, 8'h00)));
    plan.push_back(cmd_row(render_cmd(8'd0, 7'd0, 1'b0)));
    plan.push_back(cmd_row(render_cmd(8'd255, 7'd127, 1'b1)));
    plan.push_back(cfg_row(REG_DISPLAY_MODE, {13'd0, MODE_TEXT2}));
    plan.push_back(cfg_row(REG_BLINK_FG, 17'h00000));
    plan.push_back(cfg_row(REG_BLINK_BG, 17'h0000C));
    plan.push_back(cmd_row(render_cmd(8'd0, 7'd0, 1'b1)));
    plan.push_back(cmd_row(render_cmd(8'd255, 7'd79, 1'b1)));
    plan.push_back(cmd_row(render_cmd(8'd7, 7'd127, 1'b0)));
    plan.push_back(cfg_row(REG_BLINK_FG, 17'h00003));
    plan.push_back(cmd_row(render_cmd(8'd16, 7'd5, 1'b1)));
    plan.push_back(cfg_row(REG_DISPLAY_MODE, {13'd0, MODE_GRAPHIC2}));
    plan.push_back(cmd_row(render_cmd(8'd200, 7'd31, 1'b0)));
    plan.push_back(cfg_row(REG_DISPLAY_MODE, {13'd0, MODE_TEXT1}));
    plan.push_back(cmd_row(render_cmd(8'd255, 7'd39, 1'b0)));
    plan.push_back(cfg_row(REG_DISPLAY_MODE, {13'd0, MODE_TEXT1Q}));
    plan.push_back(cmd_row(render_cmd(8'd130, 7'd10, 1'b0)));
    plan.push_back(cfg_row(REG_DISPLAY_MODE, {13'd0, MODE_MULTI}));
    plan.push_back(cmd_row(render_cmd(8'd3, 7'd0, 1'b0)));
    plan.push_back(cfg_row(REG_DISPLAY_MODE, {13'd0, MODE_MULTIQ}));
    plan.push_back(cmd_row(render_cmd(8'd255, 7'd31, 1'b1)));
    plan.push_back(cfg_row(REG_DISPLAY_MODE, {13'd0, MODE_GRAPHIC3}));
    plan.push_back(cmd_row(render_cmd(8'd64, 7'd16, 1'b0)));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (plan[i]) begin
      pr = plan[i];
      if (pr.is_cfg) begin
        drain();
        write_reg(pr.idx, pr.val);
      end else if (pr.c.opcode == OP_WRITE) begin
        send(pr.c, 1'b0, '0);
      end else begin
        render(pr.c, pr.has_exp, pr.exp);
      end
    end

    // One phase per mode slot, every register rewritten each phase
    for (int p = 0; p < PhaseCount; p++) begin
      drain();
      write_reg(REG_DISPLAY_MODE, {13'($urandom), 4'(p)});
      write_reg(REG_NAME_MASK, pick_mask());
      write_reg(REG_PATTERN_MASK, pick_mask());
      write_reg(REG_COLOUR_MASK, pick_mask());
      write_reg(REG_TEXT_FG, pick_colour());
      write_reg(REG_TEXT_BG, pick_colour());
      write_reg(REG_BLINK_FG, pick_colour());
      write_reg(REG_BLINK_BG, pick_colour());
      case (sh_mode)
        MODE_TEXT2:              mode_w = 80;
        MODE_TEXT1, MODE_TEXT1Q: mode_w = 40;
        MODE_GRAPHIC1, MODE_GRAPHIC2, MODE_GRAPHIC3, MODE_MULTI, MODE_MULTIQ: mode_w = 32;
        default:                 mode_w = 42;
      endcase
      for (int k = 0; k < PhaseItems; k++) begin
        calm = (item_no >= 300 && item_no < 500);
        item_no++;
        if ($urandom_range(0, 99) < 65) begin
          c = render_cmd(8'($urandom), 7'($urandom), 1'($urandom));
          if ($urandom_range(0, 99) < 70) c.cell_column = 7'($urandom_range(0, mode_w - 1));
          render(c, 1'b0, '0);
        end else begin
          // overwrite a byte the last cell read, or anywhere
          if (fetch_cnt > 0 && $urandom_range(0, 1) == 1) begin
            c = write_cmd(fetch_addr[$urandom_range(0, fetch_cnt - 1)],
                          8'($urandom_range(0, 255)));
          end else begin
            c = write_cmd(17'($urandom), 8'($urandom_range(0, 255)));
          end
          send(c, 1'b0, '0);
        end
      end
    end

    calm = 1'b0;
    drain();
    if (mismatches == 0 && pending_cells.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
